@@ rtl/bdvb_pkg.sv @@
package bdvb_pkg;

   // Default number of slots and the configuration register's reset value.
   localparam int        DEPTH_DEFAULT = 16;
   localparam logic [4:0] CAP_RESET    = 5'd16;

   // Slot index and count widths carried in the scan wave. They cover the
   // largest supported depth of 64 slots.
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;

   typedef struct packed {
      logic        action;
      logic [7:0]  slack;
      logic [15:0] value;
      logic [7:0]  copies;
   } req_type;

   typedef struct packed {
      logic [7:0]  dropped_now;
      logic        sent;
      logic [15:0] sent_value;
      logic [4:0]  occupancy;
      logic [31:0] total_arrived;
      logic [31:0] total_dropped;
      logic [31:0] total_sent;
      logic [31:0] total_value;
   } rsp_type;

   // Scan token that walks the cell chain, one cell per cycle.
   typedef struct packed {
      logic             active;
      logic             is_tick;
      logic             best_found;
      logic [IDX_W-1:0] best_idx;
      logic [15:0]      best_value;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic             min_found;
      logic [IDX_W-1:0] min_idx;
      logic [15:0]      min_value;
      logic [CNT_W-1:0] expired;
   } wave_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_WRITE,
      CMD_CLEAR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic [IDX_W-1:0] idx;
      logic [7:0]       slack;
      logic [15:0]      value;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_SCAN,
      ST_OUT
   } state_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

endpackage

@@ rtl/bdvb_cell.sv @@
module bdvb_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  bdvb_pkg::wave_type wave_in,
   input  bdvb_pkg::cmd_type  cmd,
   output bdvb_pkg::wave_type wave_out
);

   localparam logic [bdvb_pkg::IDX_W-1:0] MY_IDX = bdvb_pkg::IDX_W'(CELL_IDX);

   logic               valid_ff, valid_in;
   logic [7:0]         slack_ff, slack_in;
   logic [15:0]        value_ff, value_in;
   bdvb_pkg::wave_type wave_ff, wave_in_next;

   always_comb begin
      logic aged_valid;
      valid_in     = valid_ff;
      slack_in     = slack_ff;
      value_in     = value_ff;
      wave_in_next = wave_in;
      aged_valid   = valid_ff;

      if (wave_in.active) begin
         if (wave_in.is_tick) begin
            // Age this slot, then let it compete for the send with its aged state.
            if (valid_ff) begin
               if (slack_ff <= 8'd1) begin
                  valid_in             = 1'b0;
                  aged_valid           = 1'b0;
                  wave_in_next.expired = wave_in.expired + 1'b1;
               end else begin
                  slack_in = slack_ff - 8'd1;
               end
            end
            if (aged_valid && (!wave_in.best_found || value_ff > wave_in.best_value)) begin
               wave_in_next.best_found = 1'b1;
               wave_in_next.best_idx   = MY_IDX;
               wave_in_next.best_value = value_ff;
            end
         end else begin
            if (!valid_ff && !wave_in.free_found) begin
               wave_in_next.free_found = 1'b1;
               wave_in_next.free_idx   = MY_IDX;
            end
            if (valid_ff && (!wave_in.min_found || value_ff < wave_in.min_value)) begin
               wave_in_next.min_found = 1'b1;
               wave_in_next.min_idx   = MY_IDX;
               wave_in_next.min_value = value_ff;
            end
         end
      end

      if (cmd.idx == MY_IDX) begin
         case (cmd.op)
            bdvb_pkg::CMD_WRITE: begin
               valid_in = 1'b1;
               slack_in = cmd.slack;
               value_in = cmd.value;
            end
            bdvb_pkg::CMD_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         wave_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         wave_ff  <= wave_in_next;
      end
   end

   always_ff @(posedge clock) begin
      slack_ff <= slack_in;
      value_ff <= value_in;
   end

   assign wave_out = wave_ff;

endmodule

@@ rtl/bounded_delay_value_buffer.sv @@
// Channel   Direction  Signals                      Payload
// request   in         req_valid / req_ready        req_data  (bdvb_pkg::req_type)
// response  out        rsp_valid / rsp_ready        rsp_data  (bdvb_pkg::rsp_type)
// csr       in         csr_we (no wait)             csr_wdata (capacity, 5 bits)
//
// Every slot lives in one cell of a chain. A scan token enters the first cell and
// moves one cell per cycle, so the length of the cell chain sets how long a tick
// and each copy of an arrival take. One request is worked on at a time.
// Reset is synchronous and active high; it empties every slot, clears the totals
// and sets the capacity to 16. A stalled response sits in the output register
// while the next request is already accepted and processed.
module bounded_delay_value_buffer #(
   parameter int QUEUE_DEPTH = bdvb_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdvb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bdvb_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [4:0]        csr_wdata
);

   localparam int HELD_W = $clog2(QUEUE_DEPTH + 1);
   // Width used to compare occupancy with the effective capacity.
   localparam int CMP_W  = 8;

   // The scan token bus: entry 0 is driven here, entry i+1 leaves cell i.
   bdvb_pkg::wave_type wave_bus [QUEUE_DEPTH+1];
   bdvb_pkg::wave_type wave_head;
   bdvb_pkg::wave_type wave_last;
   bdvb_pkg::cmd_type  cmd;
   logic [QUEUE_DEPTH-1:0] wave_act;

   bdvb_pkg::state_type state_ff, state_in;
   logic              is_tick_ff, is_tick_in;
   logic [7:0]        slack_ff, slack_in;
   logic [15:0]       value_ff, value_in;
   logic [7:0]        copies_ff, copies_in;
   logic [7:0]        drops_ff, drops_in;
   logic              sent_ff, sent_in;
   logic [15:0]       sent_value_ff, sent_value_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [31:0]       arrived_ff, arrived_in;
   logic [31:0]       dropped_ff, dropped_in;
   logic [31:0]       sent_cnt_ff, sent_cnt_in;
   logic [31:0]       value_sum_ff, value_sum_in;
   logic [4:0]        capacity_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   bdvb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] eff_cap;
   logic             room;

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         bdvb_cell #(
            .CELL_IDX (gi)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .wave_in  (wave_bus[gi]),
            .cmd      (cmd),
            .wave_out (wave_bus[gi+1])
         );
         assign wave_act[gi] = wave_bus[gi+1].active;
      end
   endgenerate

   assign wave_bus[0] = wave_head;
   assign wave_last   = wave_bus[QUEUE_DEPTH];

   // A capacity of zero behaves as one; anything above the slot count is clamped.
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(QUEUE_DEPTH)) begin
         eff_cap = CMP_W'(QUEUE_DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
      room = CMP_W'(held_ff) < eff_cap;
   end

   assign req_ready = (state_ff == bdvb_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      is_tick_in    = is_tick_ff;
      slack_in      = slack_ff;
      value_in      = value_ff;
      copies_in     = copies_ff;
      drops_in      = drops_ff;
      sent_in       = sent_ff;
      sent_value_in = sent_value_ff;
      held_in       = held_ff;
      arrived_in    = arrived_ff;
      dropped_in    = dropped_ff;
      sent_cnt_in   = sent_cnt_ff;
      value_sum_in  = value_sum_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      wave_head         = '0;
      wave_head.is_tick = is_tick_ff;
      cmd               = '0;
      cmd.op            = bdvb_pkg::CMD_NONE;
      cmd.slack         = slack_ff;
      cmd.value         = value_ff;

      // The output register empties as soon as the consumer takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         bdvb_pkg::ST_IDLE: begin
            if (req_valid) begin
               is_tick_in    = req_data.action;
               slack_in      = req_data.slack;
               value_in      = req_data.value;
               copies_in     = req_data.copies;
               drops_in      = '0;
               sent_in       = 1'b0;
               sent_value_in = '0;
               if (req_data.action) begin
                  state_in = bdvb_pkg::ST_LAUNCH;
               end else begin
                  arrived_in = bdvb_pkg::sat_add32(arrived_ff, 32'(req_data.copies));
                  // An arrival of zero copies changes nothing.
                  state_in   = (req_data.copies == 8'd0) ? bdvb_pkg::ST_OUT
                                                          : bdvb_pkg::ST_LAUNCH;
               end
            end
         end
         bdvb_pkg::ST_LAUNCH: begin
            wave_head.active = 1'b1;
            state_in         = bdvb_pkg::ST_SCAN;
         end
         bdvb_pkg::ST_SCAN: begin
            if (wave_last.active) begin
               if (is_tick_ff) begin
                  // Expired packets are already gone; send the best survivor.
                  drops_in   = 8'(wave_last.expired);
                  dropped_in = bdvb_pkg::sat_add32(dropped_ff, 32'(wave_last.expired));
                  if (wave_last.best_found) begin
                     cmd.op        = bdvb_pkg::CMD_CLEAR;
                     cmd.idx       = wave_last.best_idx;
                     sent_in       = 1'b1;
                     sent_value_in = wave_last.best_value;
                     sent_cnt_in   = bdvb_pkg::sat_add32(sent_cnt_ff, 32'd1);
                     value_sum_in  = bdvb_pkg::sat_add32(value_sum_ff,
                                                         32'(wave_last.best_value));
                  end
                  held_in  = held_ff - HELD_W'(wave_last.expired)
                             - HELD_W'(wave_last.best_found);
                  state_in = bdvb_pkg::ST_OUT;
               end else begin
                  // Store one copy: lowest free slot, or evict the lowest value.
                  cmd.op = bdvb_pkg::CMD_WRITE;
                  if (room) begin
                     cmd.idx = wave_last.free_idx;
                     held_in = held_ff + HELD_W'(1);
                  end else begin
                     cmd.idx    = wave_last.min_idx;
                     drops_in   = drops_ff + 8'd1;
                     dropped_in = bdvb_pkg::sat_add32(dropped_ff, 32'd1);
                  end
                  copies_in = copies_ff - 8'd1;
                  state_in  = (copies_ff == 8'd1) ? bdvb_pkg::ST_OUT
                                                  : bdvb_pkg::ST_LAUNCH;
               end
            end
         end
         bdvb_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.dropped_now   = drops_ff;
               rsp_data_in.sent          = sent_ff;
               rsp_data_in.sent_value    = sent_value_ff;
               rsp_data_in.occupancy     = 5'(held_ff);
               rsp_data_in.total_arrived = arrived_ff;
               rsp_data_in.total_dropped = dropped_ff;
               rsp_data_in.total_sent    = sent_cnt_ff;
               rsp_data_in.total_value   = value_sum_ff;
               state_in                  = bdvb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bdvb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdvb_pkg::ST_IDLE;
         held_ff      <= '0;
         arrived_ff   <= '0;
         dropped_ff   <= '0;
         sent_cnt_ff  <= '0;
         value_sum_ff <= '0;
         capacity_ff  <= bdvb_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         arrived_ff   <= arrived_in;
         dropped_ff   <= dropped_in;
         sent_cnt_ff  <= sent_cnt_in;
         value_sum_ff <= value_sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      is_tick_ff    <= is_tick_in;
      slack_ff      <= slack_in;
      value_ff      <= value_in;
      copies_ff     <= copies_in;
      drops_ff      <= drops_in;
      sent_ff       <= sent_in;
      sent_value_ff <= sent_value_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // The occupancy count never exceeds the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_W'(QUEUE_DEPTH))
      else $error("occupancy count above slot count");

   // At most one scan token is in flight in the chain.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(wave_act))
      else $error("more than one scan token in the cell chain");

   // A token only returns while the controller waits for it.
   assert property (@(posedge clock) disable iff (reset)
      wave_last.active |-> state_ff == bdvb_pkg::ST_SCAN)
      else $error("scan token returned outside the scan state");

   // With room left, the arrival scan must have found a free slot.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdvb_pkg::ST_SCAN && wave_last.active && !is_tick_ff && room)
         |-> wave_last.free_found)
      else $error("no free slot found although occupancy is below capacity");

endmodule

@@ dv/bounded_delay_value_buffer_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the bounded-delay value buffer.
//
// The bench keeps its own copy of the slot file and the running totals and
// works out, for every request the block accepts, the response it must
// return. Responses are checked in order against that list, field by field.
//
// The run opens with a short hand-written table. Its first rows carry their
// answers typed in, and the rest are checked against the slot file copy.
// After that come ten random phases. Each phase starts with a capacity write
// while the block is idle. Both sides idle at random, and two phases hold the
// response side off for a long stretch so that the block backs up and
// stalls its request side.
module bounded_delay_value_buffer_tb;

   localparam int   SLOTS       = bdvb_pkg::DEPTH_DEFAULT;
   localparam int   PHASES      = 10;
   localparam int   PHASE_ITEMS = 165;
   localparam int   HOLD_CYCLES = 400;
   localparam logic ACT_ARRIVE  = 1'b0;
   localparam logic ACT_TICK    = 1'b1;

   // One row of the opening table. When typed is set, result is the answer
   // read straight off the behavior. Otherwise the slot file copy decides.
   typedef struct packed {
      bdvb_pkg::req_type item;
      logic              typed;
      bdvb_pkg::rsp_type result;
   } buffer_step_type;

   localparam bdvb_pkg::rsp_type NO_RESULT = '0;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   bdvb_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   bdvb_pkg::rsp_type rsp_data;
   logic              csr_we    = 1'b0;
   logic [4:0]        csr_wdata = '0;

   bounded_delay_value_buffer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // The bench's own copy of the slot file, the capacity and the totals.
   bit          slot_live  [SLOTS];
   logic [7:0]  slot_ttl   [SLOTS];
   logic [15:0] slot_worth [SLOTS];
   logic [4:0]  capacity_reg  = bdvb_pkg::CAP_RESET;
   logic [31:0] arrived_total = '0;
   logic [31:0] dropped_total = '0;
   logic [31:0] sent_total    = '0;
   logic [31:0] worth_total   = '0;

   // Responses still owed by the block, oldest first.
   bdvb_pkg::rsp_type pending_results [$];
   int                mismatch_count  = 0;

   // Idle controls shared by the two sides. A quiet side never idles, and a
   // nonzero hold makes the response side refuse everything for that long.
   bit req_quiet       = 1'b0;
   bit rsp_quiet       = 1'b0;
   int rsp_hold_cycles = 0;

   // The capacity settings that the random phases walk through. They include
   // zero and the all-ones code, both of which the block clamps, and a drop
   // to 2 right after the opening table has left the buffer full.
   logic [4:0] capacity_plan [PHASES] =
      '{5'd2, 5'd0, 5'd31, 5'd1, 5'd17, 5'd16, 5'd8, 5'd3, 5'd12, 5'd5};

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
      if (a > 32'hFFFF_FFFF - b) return 32'hFFFF_FFFF;
      return a + b;
   endfunction

   function automatic int live_slots();
      int n;
      n = 0;
      foreach (slot_live[i]) if (slot_live[i]) n++;
      return n;
   endfunction

   // Apply one request to the slot file copy and return the response it
   // causes.
   task automatic run_buffer_item(input bdvb_pkg::req_type item,
                                  output bdvb_pkg::rsp_type res);
      int drops;
      int limit;
      int pick;
      int sent_slot;
      res   = '0;
      drops = 0;
      // Capacity 0 behaves as 1, and anything above the slot count as full depth.
      limit = capacity_reg;
      if (limit < 1) limit = 1;
      if (limit > SLOTS) limit = SLOTS;
      if (item.action == ACT_ARRIVE) begin
         arrived_total = add_clamped(arrived_total, 32'(item.copies));
         repeat (item.copies) begin
            pick = -1;
            if (live_slots() < limit) begin
               for (int i = SLOTS - 1; i >= 0; i--) if (!slot_live[i]) pick = i;
            end else begin
               // Full, or over a capacity lowered after filling: the cheapest
               // packet gives up its slot, on ties the lowest slot. The newcomer
               // goes in even when it is worth less.
               for (int i = 0; i < SLOTS; i++)
                  if (slot_live[i] && (pick < 0 || slot_worth[i] < slot_worth[pick]))
                     pick = i;
               drops++;
            end
            if (pick >= 0) begin
               slot_live[pick]  = 1'b1;
               slot_ttl[pick]   = item.slack;
               slot_worth[pick] = item.value;
            end
         end
      end else begin
         // Every packet ages before the send. Slack 0 or 1 runs out here.
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
               if (slot_ttl[i] <= 8'd1) begin
                  slot_live[i] = 1'b0;
                  drops++;
               end else begin
                  slot_ttl[i] = slot_ttl[i] - 8'd1;
               end
            end
         end
         sent_slot = -1;
         for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && (sent_slot < 0 || slot_worth[i] > slot_worth[sent_slot]))
               sent_slot = i;
         if (sent_slot >= 0) begin
            res.sent       = 1'b1;
            res.sent_value = slot_worth[sent_slot];
            slot_live[sent_slot] = 1'b0;
            sent_total  = add_clamped(sent_total, 32'd1);
            worth_total = add_clamped(worth_total, 32'(slot_worth[sent_slot]));
         end
      end
      dropped_total     = add_clamped(dropped_total, 32'(drops));
      res.dropped_now   = (drops > 255) ? 8'd255 : 8'(drops);
      res.occupancy     = 5'(live_slots());
      res.total_arrived = arrived_total;
      res.total_dropped = dropped_total;
      res.total_sent    = sent_total;
      res.total_value   = worth_total;
   endtask

   function automatic bdvb_pkg::req_type arrive(input int unsigned slk,
                                                input int unsigned val,
                                                input int unsigned cnt);
      bdvb_pkg::req_type r;
      r.action = ACT_ARRIVE;
      r.slack  = 8'(slk);
      r.value  = 16'(val);
      r.copies = 8'(cnt);
      return r;
   endfunction

   // A tick ignores the other fields, so they carry random bits.
   function automatic bdvb_pkg::req_type tick_item();
      bdvb_pkg::req_type r;
      r.action = ACT_TICK;
      r.slack  = 8'($urandom);
      r.value  = 16'($urandom);
      r.copies = 8'($urandom);
      return r;
   endfunction

   function automatic bdvb_pkg::rsp_type result_of(
         input int unsigned dn, input int unsigned snt,
         input int unsigned sv, input int unsigned occ,
         input int unsigned ta, input int unsigned td,
         input int unsigned ts, input int unsigned tv);
      bdvb_pkg::rsp_type r;
      r.dropped_now   = 8'(dn);
      r.sent          = 1'(snt);
      r.sent_value    = 16'(sv);
      r.occupancy     = 5'(occ);
      r.total_arrived = ta;
      r.total_dropped = td;
      r.total_sent    = ts;
      r.total_value   = tv;
      return r;
   endfunction

   task automatic flag_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   // Offer one request and return at the edge that accepts it. Valid stays
   // high afterwards, so a back-to-back request never lowers and raises it in
   // the same step. The caller lowers it when the stream pauses.
   task automatic offer_request(input bdvb_pkg::req_type item);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Response side. It stalls at random before each response, or for a long
   // stretch when the request side asks for one, and checks every response it
   // takes against the oldest one still owed.
   initial begin : response_side
      int                stall;
      bdvb_pkg::rsp_type want;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = rsp_quiet ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: response expected none, got 0x%h", $time, rsp_data);
         end else begin
            want = pending_results.pop_front();
            flag_field("dropped_now", 32'(want.dropped_now), 32'(rsp_data.dropped_now));
            flag_field("sent", 32'(want.sent), 32'(rsp_data.sent));
            flag_field("sent_value", 32'(want.sent_value), 32'(rsp_data.sent_value));
            flag_field("occupancy", 32'(want.occupancy), 32'(rsp_data.occupancy));
            flag_field("total_arrived", want.total_arrived, rsp_data.total_arrived);
            flag_field("total_dropped", want.total_dropped, rsp_data.total_dropped);
            flag_field("total_sent", want.total_sent, rsp_data.total_sent);
            flag_field("total_value", want.total_value, rsp_data.total_value);
         end
      end
   end

   // Request side: reset, the opening table, the random phases, then drain.
   initial begin : request_side
      buffer_step_type   opening [$];
      buffer_step_type   row;
      bdvb_pkg::req_type item;
      bdvb_pkg::rsp_type outcome;
      logic [4:0]        next_cap;
      int                roll;
      int                arrive_pct;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // A tick on the empty buffer sends nothing, and an arrival of zero
      // copies changes nothing, even at the largest slack and value.
      opening.push_back({tick_item(), 1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 0)});
      opening.push_back({arrive(255, 16'hFFFF, 0), 1'b1, result_of(0, 0, 0, 0, 0, 0, 0, 0)});
      // A packet stored with slack 0 waits for the next tick and expires there.
      opening.push_back({arrive(0, 0, 1), 1'b1, result_of(0, 0, 0, 1, 1, 0, 0, 0)});
      opening.push_back({tick_item(), 1'b1, result_of(1, 0, 0, 0, 1, 1, 0, 0)});
      // The largest value and slack go out on the next tick.
      opening.push_back({arrive(255, 16'hFFFF, 1), 1'b1, result_of(0, 0, 0, 1, 2, 1, 0, 0)});
      opening.push_back({tick_item(), 1'b1,
                         result_of(0, 1, 16'hFFFF, 0, 2, 1, 1, 16'hFFFF)});
      // Slack 1 expires on the first tick. Equal values test the tie order.
      // Aging happens before the send.
      opening.push_back({arrive(1, 16'h1234, 2), 1'b0, NO_RESULT});
      opening.push_back({tick_item(), 1'b0, NO_RESULT});
      opening.push_back({arrive(2, 5, 3), 1'b0, NO_RESULT});
      opening.push_back({arrive(10, 7, 1), 1'b0, NO_RESULT});
      opening.push_back({tick_item(), 1'b0, NO_RESULT});
      opening.push_back({tick_item(), 1'b0, NO_RESULT});
      // The largest copy count fills the buffer and then evicts on every copy.
      // A lower-valued newcomer still displaces the cheapest stored packet.
      opening.push_back({arrive(8'hAA, 16'h5555, 255), 1'b0, NO_RESULT});
      opening.push_back({arrive(8'h55, 16'hAAAA, 20), 1'b0, NO_RESULT});
      opening.push_back({arrive(3, 0, 1), 1'b0, NO_RESULT});
      opening.push_back({tick_item(), 1'b0, NO_RESULT});
      opening.push_back({arrive(8'h80, 16'h8000, 128), 1'b0, NO_RESULT});
      opening.push_back({tick_item(), 1'b0, NO_RESULT});
      opening.push_back({tick_item(), 1'b0, NO_RESULT});
      // This leaves the buffer full, so the first phase lowers the capacity
      // below the occupancy.
      opening.push_back({arrive(4, 1, 8), 1'b0, NO_RESULT});

      foreach (opening[n]) begin
         row = opening[n];
         offer_request(row.item);
         run_buffer_item(row.item, outcome);
         pending_results.push_back(row.typed ? row.result : outcome);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // The capacity is only written once every owed response has been
         // taken. Each request yields exactly one response, so the block is
         // idle at that point.
         req_valid <= 1'b0;
         while (pending_results.size() != 0) @(posedge clock);
         next_cap = (phase == 8) ? 5'($urandom) : capacity_plan[phase];
         csr_we    <= 1'b1;
         csr_wdata <= next_cap;
         @(posedge clock);
         csr_we <= 1'b0;
         capacity_reg = next_cap;

         // The share of arrivals moves between phases, so the buffer spends
         // time both nearly empty and packed.
         arrive_pct = 35 + 10 * (phase % 4);
         req_quiet  = ($urandom_range(0, 3) == 0);
         rsp_quiet  = ($urandom_range(0, 3) == 0);
         if (phase == 1 || phase == 6) begin
            req_quiet       = 1'b1;
            rsp_hold_cycles = HOLD_CYCLES;
         end

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < arrive_pct) begin
               item.action = ACT_ARRIVE;
            end else begin
               item.action = ACT_TICK;
            end
            // Mostly short slacks so that packets expire, sometimes any slack.
            // Narrow values produce ties for both the eviction and the send.
            item.slack = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 6)) : 8'($urandom);
            item.value = ($urandom_range(0, 9) < 6) ? 16'($urandom) : 16'($urandom_range(0, 3));
            // Each copy costs a full scan, so large counts stay rare.
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               item.copies = 8'($urandom);
            end else if (roll == 3) begin
               item.copies = 8'd255;
            end else begin
               item.copies = 8'($urandom_range(0, 4));
            end
            offer_request(item);
            run_buffer_item(item, outcome);
            pending_results.push_back(outcome);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // Wait a few scans longer, so that any extra response shows up.
      repeat (4 * SLOTS) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // A correct run takes well under a millisecond of simulated time.
   initial begin : watchdog
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

@@ bounded_delay_value_buffer.f @@
rtl/bdvb_pkg.sv
rtl/bdvb_cell.sv
rtl/bounded_delay_value_buffer.sv
dv/bounded_delay_value_buffer_tb.sv
